// ----- rtl/btn_pkg.sv -----
package btn_pkg;

    localparam int SLOPE_W    = 32;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int DIV_W      = 49;
    localparam int RECIP_BIT  = 32;
    localparam int QX_W       = 22;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SLOPES = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [FRAC_W-1:0]  FRAC_ONE  = 17'h10000;
    localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SL_FIRST,
        S_SL_GAP,
        S_SL_DIV,
        S_Q_LOW,
        S_Q_HIGH,
        S_Q_SEARCH,
        S_Q_MUL,
        S_Q_DIV,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/btn_div.sv -----
module btn_div #(
    parameter int DVD_W = 49,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // restoring step, one quotient bit per cycle
                r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/btn_mul.sv -----
module btn_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_product
);

    localparam int PW = A_W + B_W;
    localparam int CW = $clog2(B_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [PW-1:0]  r_acc;

    logic [PW-1:0]  w_addend;

    assign w_addend = r_b[B_W-1] ? PW'(r_a) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                // msb first shift and add
                r_acc <= {r_acc[PW-2:0], 1'b0} + w_addend;
                r_b   <= {r_b[B_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ----- rtl/breakpoint_table_normalizer.sv -----
// channel   dir  fields (lsb first)                          transfer when
// s_axis    in   tdata: op[1:0] point_index[5:2] sample[37:6] tvalid & tready
// m_axis    out  tdata: fraction[16:0]                        tvalid & tready
//
// write breakpoint goes from idle straight to the finish state, other unused codes likewise
// slope update: walks the gaps in order, one divide on the 49-step divider per rising gap
// query: a search over the breakpoints, then up to two 32-step serial multiplies
// synchronous active-low reset clears breakpoints and slopes to zero
// s_axis_tready is high only when idle; a held result does not block the next input,
// but the item after it waits in the finish state until the result register frees up
module breakpoint_table_normalizer #(
    parameter int NUM_POINTS  = 10,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // op[1:0], point_index[5:2], sample[37:6], zero fill above
    input  logic [btn_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // fraction[16:0], zero fill above
    output logic [btn_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    localparam int VW  = VALUE_WIDTH;
    localparam int IW  = $clog2(NUM_POINTS);
    localparam int SW  = (NUM_POINTS > 2) ? $clog2(NUM_POINTS - 1) : 1;
    localparam int SLW = btn_pkg::SLOPE_W;
    localparam int MAW = (VW > SLW) ? VW : SLW;
    localparam int PW  = MAW + SLW;
    localparam int PXW = (PW > 64) ? PW : 65;
    localparam int DW  = btn_pkg::DIV_W;
    localparam int FW  = btn_pkg::FRAC_W;
    localparam logic [VW-1:0] VSIGN = {1'b1, {(VW-1){1'b0}}};
    // position at which the scaled fraction passes full scale
    localparam logic [DW-1:0] POS_SAT = DW'((int'(btn_pkg::FRAC_ONE) + 1) * NUM_POINTS);
    // reciprocal of the point count, exact for positions below POS_SAT
    localparam logic [SLW-1:0] DIV_RECIP =
        SLW'((64'd1 << btn_pkg::RECIP_BIT) / NUM_POINTS + 1);

    btn_pkg::t_state r_state, n_state;

    logic [VW-1:0]  r_bp [NUM_POINTS];
    logic [SLW-1:0] r_sl [NUM_POINTS-1];

    logic [IW-1:0]  r_idx, n_idx;
    logic [VW-1:0]  r_prev, n_prev;
    logic [VW-1:0]  r_val, n_val;
    logic [FW-1:0]  r_frac, n_frac;
    logic           r_out_valid, n_out_valid;
    logic [FW-1:0]  r_out_data, n_out_data;

    logic [1:0]     w_op;
    logic [5:0]     w_pidx;
    logic [63:0]    w_sx;
    logic [VW-1:0]  w_in_biased;
    logic           w_bp_we;
    logic [IW-1:0]  w_bp_waddr;
    logic           w_sl_we;
    logic [SLW-1:0] w_sl_data;
    logic [IW-1:0]  w_sidx;
    logic [VW-1:0]  w_bp_rd;
    logic [SLW-1:0] w_sl_rd;
    logic           w_last;
    logic [VW-1:0]  w_off;

    logic           w_div_start;
    logic           w_div_done;
    logic           w_mul_start;
    logic           w_mul_done;
    logic [DW-1:0]  w_div_dvd;
    logic [VW-1:0]  w_div_dvs;
    logic [DW-1:0]  w_div_q;
    logic [MAW-1:0] w_mul_a;
    logic [SLW-1:0] w_mul_b;
    logic [PW-1:0]  w_mul_p;
    logic [PXW-1:0] w_pext;
    logic           w_ovf;
    logic [DW-1:0]  w_pos;
    logic [SLW-1:0] w_recip;

    assign w_op        = i_s_axis_tdata[1:0];
    assign w_pidx      = 6'(i_s_axis_tdata[5:2]);
    assign w_sx        = {{32{i_s_axis_tdata[37]}}, i_s_axis_tdata[37:6]};
    assign w_in_biased = w_sx[VW-1:0] ^ VSIGN;

    assign w_bp_rd = r_bp[r_idx];
    assign w_sl_rd = r_sl[r_idx[SW-1:0]];
    assign w_sidx  = r_idx - 1'b1;
    assign w_last  = r_idx == IW'(NUM_POINTS - 1);
    assign w_off   = r_val - w_bp_rd;

    assign w_pext  = PXW'(w_mul_p);
    assign w_ovf   = |w_pext[PXW-1:64];
    assign w_pos   = DW'(w_pext[63:btn_pkg::FRAC_SHIFT])
                   + (DW'(r_idx) << btn_pkg::FRAC_SHIFT);
    assign w_recip = (|w_div_q[DW-1:btn_pkg::RECIP_BIT]) ? btn_pkg::SLOPE_MAX
                                                         : w_div_q[SLW-1:0];

    btn_div #(
        .DVD_W (DW),
        .DVS_W (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    btn_mul #(
        .A_W (MAW),
        .B_W (SLW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btn_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_bp[i] <= VSIGN;
            end
            for (int i = 0; i < NUM_POINTS - 1; i++) begin
                r_sl[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (w_bp_we) begin
                r_bp[w_bp_waddr] <= w_in_biased;
            end
            if (w_sl_we) begin
                r_sl[w_sidx[SW-1:0]] <= w_sl_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_val      <= n_val;
        r_frac     <= n_frac;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_val       = r_val;
        n_frac      = r_frac;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_bp_we     = 1'b0;
        w_bp_waddr  = w_pidx[IW-1:0];
        w_sl_we     = 1'b0;
        w_sl_data   = '0;
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dvs   = '0;
        w_mul_start = 1'b0;
        w_mul_a     = MAW'(w_off);
        w_mul_b     = w_sl_rd;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            btn_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_frac  = '0;
                    n_state = btn_pkg::S_FINISH;
                    unique case (w_op)
                        btn_pkg::OP_WRITE: begin
                            w_bp_we = w_pidx < 6'(NUM_POINTS);
                        end
                        btn_pkg::OP_SLOPES: begin
                            n_idx   = '0;
                            n_state = btn_pkg::S_SL_FIRST;
                        end
                        btn_pkg::OP_QUERY: begin
                            n_val   = w_in_biased;
                            n_idx   = '0;
                            n_state = btn_pkg::S_Q_LOW;
                        end
                        default: begin
                            n_frac = '0;
                        end
                    endcase
                end
            end
            btn_pkg::S_SL_FIRST: begin
                n_prev  = w_bp_rd;
                n_idx   = r_idx + 1'b1;
                n_state = btn_pkg::S_SL_GAP;
            end
            btn_pkg::S_SL_GAP: begin
                n_prev = w_bp_rd;
                if (w_bp_rd > r_prev) begin
                    w_div_start = 1'b1;
                    w_div_dvd   = DW'(1) << btn_pkg::RECIP_BIT;
                    w_div_dvs   = w_bp_rd - r_prev;
                    n_state     = btn_pkg::S_SL_DIV;
                end else begin
                    w_sl_we = 1'b1;
                    if (w_last) begin
                        n_frac  = '0;
                        n_state = btn_pkg::S_FINISH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            btn_pkg::S_SL_DIV: begin
                if (w_div_done) begin
                    w_sl_we   = 1'b1;
                    w_sl_data = w_recip;
                    if (w_last) begin
                        n_frac  = '0;
                        n_state = btn_pkg::S_FINISH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = btn_pkg::S_SL_GAP;
                    end
                end
            end
            btn_pkg::S_Q_LOW: begin
                if (r_val < w_bp_rd) begin
                    n_frac  = '0;
                    n_state = btn_pkg::S_FINISH;
                end else begin
                    n_idx   = IW'(NUM_POINTS - 1);
                    n_state = btn_pkg::S_Q_HIGH;
                end
            end
            btn_pkg::S_Q_HIGH: begin
                if (r_val >= w_bp_rd) begin
                    n_frac  = btn_pkg::FRAC_ONE;
                    n_state = btn_pkg::S_FINISH;
                end else begin
                    n_idx   = IW'(NUM_POINTS - 2);
                    n_state = btn_pkg::S_Q_SEARCH;
                end
            end
            btn_pkg::S_Q_SEARCH: begin
                // the first breakpoint is known to be at or below the sample
                if (r_val >= w_bp_rd) begin
                    w_mul_start = 1'b1;
                    n_state     = btn_pkg::S_Q_MUL;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            btn_pkg::S_Q_MUL: begin
                if (w_mul_done) begin
                    if (w_ovf || w_pos >= POS_SAT) begin
                        n_frac  = btn_pkg::FRAC_ONE;
                        n_state = btn_pkg::S_FINISH;
                    end else begin
                        // divide by the point count as a reciprocal multiply
                        w_mul_start = 1'b1;
                        w_mul_a     = MAW'(DIV_RECIP);
                        w_mul_b     = SLW'(w_pos[btn_pkg::QX_W-1:0]);
                        n_state     = btn_pkg::S_Q_DIV;
                    end
                end
            end
            btn_pkg::S_Q_DIV: begin
                if (w_mul_done) begin
                    n_frac  = w_mul_p[btn_pkg::RECIP_BIT +: FW];
                    n_state = btn_pkg::S_FINISH;
                end
            end
            btn_pkg::S_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_frac;
                    n_state     = btn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btn_pkg::S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = r_state == btn_pkg::S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = btn_pkg::OUT_DATA_W'(r_out_data);

endmodule
